// ===== hw/rtl/cartridge_bank_mapper_macros.svh =====
// Assertion macros shared by the cartridge bank mapper modules.
// Both expect signals named clk and rst in the enclosing module.
`ifndef CARTRIDGE_BANK_MAPPER_MACROS_SVH
`define CARTRIDGE_BANK_MAPPER_MACROS_SVH

`define CBM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define CBM_ASSERT_ALWAYS(label, expr, msg) \
  `CBM_ASSERT(label, (1'b1 |-> (expr)), msg)

`endif

// ===== hw/rtl/cbm_pkg.sv =====
package cbm_pkg;

  localparam int RAM_BANKS      = 4;
  localparam int RAM_BANK_BYTES = 8192;
  localparam int ROM_BANK_BYTES = 16384;

  localparam int RAM_DEPTH = RAM_BANKS * RAM_BANK_BYTES;
  localparam int RAM_AW    = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
  localparam int RAM_OFS_W = $clog2(RAM_BANK_BYTES);
  localparam int ROM_OFS_W = $clog2(ROM_BANK_BYTES);

  localparam int ROM_BANK_W = 5;
  localparam int RAM_BANK_W = 2;
  localparam int ROM_ADDR_W = ROM_BANK_W + ROM_OFS_W;

  // Address regions, selected by address bits 15:13.
  localparam logic [2:0] REGION_RAM_EN   = 3'd0;
  localparam logic [2:0] REGION_ROM_BANK = 3'd1;
  localparam logic [2:0] REGION_RAM_BANK = 3'd2;
  localparam logic [2:0] REGION_MODE     = 3'd3;
  localparam logic [2:0] REGION_CART_RAM = 3'd5;

  localparam logic [3:0] RAM_EN_KEY = 4'hA;

  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  typedef enum logic [2:0] {
    ST_ROM      = 3'd0,
    ST_RAM      = 3'd1,
    ST_WRITE    = 3'd2,
    ST_RAM_OFF  = 3'd3,
    ST_UNMAPPED = 3'd4
  } status_t;

  typedef struct packed {
    logic              en;
    logic              we;
    logic [RAM_AW-1:0] addr;
    logic [7:0]        wdata;
  } ram_req_t;

  typedef struct packed {
    status_t                 status;
    logic [ROM_ADDR_W-1:0]   rom_address;
  } meta_t;

  // Reduces a RAM bank number modulo the number of fitted banks.
  function automatic logic [RAM_BANK_W-1:0] ram_bank_sel(input logic [RAM_BANK_W-1:0] b);
    logic [RAM_BANK_W:0] v;
    v = {1'b0, b};
    for (int i = 0; i < (1 << RAM_BANK_W) - 1; i++) begin
      if (v >= (RAM_BANK_W + 1)'(RAM_BANKS)) begin
        v = v - (RAM_BANK_W + 1)'(RAM_BANKS);
      end
    end
    return v[RAM_BANK_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/cbm_if.sv =====
interface cbm_req_if;
  import cbm_pkg::*;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] address;
  logic [7:0]  write_data;

  modport source (output valid, kind, address, write_data, input ready);
  modport sink (input valid, kind, address, write_data, output ready);
endinterface

interface cbm_rsp_if;
  import cbm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [2:0]            status;
  logic [ROM_ADDR_W-1:0] rom_address;
  logic [7:0]            read_data;

  modport source (output valid, status, rom_address, read_data, input ready);
  modport sink (input valid, status, rom_address, read_data, output ready);
endinterface

// ===== hw/rtl/cbm_ram.sv =====
module cbm_ram #(
  parameter int DEPTH = 32768,
  parameter int WIDTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ===== hw/rtl/cbm_ctrl.sv =====
module cbm_ctrl import cbm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic        kind,
  input  logic [15:0] address,
  input  logic [7:0]  write_data,
  output ram_req_t    ram_req,
  output meta_t       meta
);

  logic [ROM_BANK_W-1:0] rom_bank;
  logic [ROM_BANK_W-1:0] rom_bank_next;
  logic [RAM_BANK_W-1:0] ram_bank;
  logic [RAM_BANK_W-1:0] ram_bank_next;
  logic                  ram_enabled;
  logic                  ram_enabled_next;
  logic [2:0]            region;
  logic [RAM_BANK_W-1:0] bank_used;

  assign region    = address[15:13];
  assign bank_used = ram_bank_sel(ram_bank);

  always_comb begin
    rom_bank_next    = rom_bank;
    ram_bank_next    = ram_bank;
    ram_enabled_next = ram_enabled;
    ram_req.en       = 1'b0;
    ram_req.we       = kind;
    ram_req.addr     = RAM_AW'(RAM_AW'(bank_used) * RAM_BANK_BYTES)
                     + RAM_AW'(address[RAM_OFS_W-1:0]);
    ram_req.wdata    = write_data;
    meta.status      = ST_UNMAPPED;
    meta.rom_address = '0;
    if (kind == KIND_WRITE) begin
      meta.status = ST_WRITE;
      case (region)
        REGION_RAM_EN: begin
          ram_enabled_next = (write_data[3:0] == RAM_EN_KEY);
        end
        REGION_ROM_BANK: begin
          rom_bank_next = (write_data[ROM_BANK_W-1:0] == '0) ? ROM_BANK_W'(1)
                                                             : write_data[ROM_BANK_W-1:0];
        end
        REGION_RAM_BANK: begin
          ram_bank_next = write_data[RAM_BANK_W-1:0];
        end
        REGION_CART_RAM: begin
          ram_req.en = accept && ram_enabled;
        end
        default: begin
        end
      endcase
    end else begin
      if (region inside {REGION_RAM_EN, REGION_ROM_BANK}) begin
        meta.status      = ST_ROM;
        meta.rom_address = {{ROM_BANK_W{1'b0}}, address[ROM_OFS_W-1:0]};
      end else if (region inside {REGION_RAM_BANK, REGION_MODE}) begin
        meta.status      = ST_ROM;
        meta.rom_address = {rom_bank, address[ROM_OFS_W-1:0]};
      end else if (region == REGION_CART_RAM) begin
        meta.status = ram_enabled ? ST_RAM : ST_RAM_OFF;
        ram_req.en  = accept && ram_enabled;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_bank    <= ROM_BANK_W'(1);
      ram_bank    <= '0;
      ram_enabled <= 1'b0;
    end else if (accept) begin
      rom_bank    <= rom_bank_next;
      ram_bank    <= ram_bank_next;
      ram_enabled <= ram_enabled_next;
    end
  end

`include "cartridge_bank_mapper_macros.svh"

  `CBM_ASSERT_ALWAYS(a_rom_bank_nonzero, rom_bank != '0, "ROM bank register holds zero")
  `CBM_ASSERT(a_ram_only_when_enabled, (ram_req.en |-> (ram_enabled && accept)), "RAM access while disabled")
  `CBM_ASSERT(a_banks_hold_idle, (!accept |=> ($stable(rom_bank) && $stable(ram_bank) && $stable(ram_enabled))), "Bank state changed without an item")

endmodule

// ===== hw/rtl/cartridge_bank_mapper.sv =====
// Cartridge bank mapper: takes one byte bus access per item and returns one result item for
// each. The block sustains one item per clock cycle as long as results are taken; each result
// passes through the cartridge RAM read stage and then the output register after its item is
// accepted, which lets the block take one more item while a result waits to be taken. The rate
// is set by the single-port cartridge RAM, which serves one read or one write per cycle. The RAM
// is not cleared at reset, so its contents are undefined until written.
module cartridge_bank_mapper import cbm_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  cbm_req_if.sink       req,
  cbm_rsp_if.source     rsp
);

  logic                  accept;
  logic                  s1_move;
  logic                  s1_valid;
  meta_t                 s1_meta;
  ram_req_t              ram_req;
  meta_t                 meta;
  logic [7:0]            ram_rdata;
  logic                  out_valid;
  logic [2:0]            out_status;
  logic [ROM_ADDR_W-1:0] out_rom_address;
  logic [7:0]            out_read_data;

  assign s1_move   = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_move;
  assign accept    = req.valid && req.ready;

  cbm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .kind       (req.kind),
    .address    (req.address),
    .write_data (req.write_data),
    .ram_req    (ram_req),
    .meta       (meta)
  );

  cbm_ram #(
    .DEPTH (RAM_DEPTH),
    .WIDTH (8)
  ) u_ram (
    .clk   (clk),
    .en    (ram_req.en),
    .we    (ram_req.we),
    .addr  (ram_req.addr),
    .wdata (ram_req.wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_meta <= meta;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_status      <= s1_meta.status;
      out_rom_address <= s1_meta.rom_address;
      out_read_data   <= (s1_meta.status == ST_RAM) ? ram_rdata : 8'h00;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.rom_address = out_rom_address;
  assign rsp.read_data   = out_read_data;

`include "cartridge_bank_mapper_macros.svh"

  `CBM_ASSERT(a_accept_fills_s1, (accept |=> s1_valid), "Accepted item did not reach the read stage")
  `CBM_ASSERT(a_s1_holds_on_stall, ((s1_valid && !s1_move) |=> (s1_valid && $stable(s1_meta))), "Read stage lost an item under stall")
  `CBM_ASSERT(a_rom_addr_zero, ((out_valid && out_status != ST_ROM) |-> (out_rom_address == '0)), "ROM address set on a non-ROM result")
  `CBM_ASSERT(a_rdata_zero, ((out_valid && out_status != ST_RAM) |-> (out_read_data == 8'h00)), "Read data set on a non-RAM result")

endmodule
